// ===== rtl/wma_pkg.sv =====
package wma_pkg;

    localparam int SMP_W      = 24;
    localparam int SUM_W      = 30;
    localparam int TS_W       = 32;
    localparam int LEN_W      = 6;
    localparam int RING_DEPTH = 64;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int DIV_STEPS  = SUM_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_DIV,
        S_FIX,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the incoming word
        logic rd;        // read the ring slot under the write index
        logic upd;       // update sum, ring and held values
        logic div_step;  // one quotient bit
        logic div_fin;   // apply sign and latch the average
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic wrap;      // this word closes the window
        logic div_last;  // final quotient bit in this cycle
        logic out_free;  // output register can take a result
    } t_dp_sts;

endpackage

// ===== rtl/wma_in_if.sv =====
interface wma_in_if import wma_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample;
    logic [TS_W-1:0]         time_stamp;

    modport source (output valid, output sample, output time_stamp, input ready);
    modport sink (input valid, input sample, input time_stamp, output ready);
endinterface

// ===== rtl/wma_out_if.sv =====
interface wma_out_if import wma_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    updated;
    logic signed [SMP_W-1:0] average;
    logic signed [SUM_W-1:0] running_sum;
    logic [TS_W-1:0]         latched_stamp;

    modport source (
        output valid, output updated, output average, output running_sum,
        output latched_stamp, input ready
    );
    modport sink (
        input valid, input updated, input average, input running_sum,
        input latched_stamp, output ready
    );
endinterface

// ===== rtl/wma_ctrl.sv =====
module wma_ctrl import wma_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = i_sts.wrap ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
            end
            S_SUM: begin
                o_cmd.upd = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_FIX: begin
                o_cmd.div_fin = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/wma_datapath.sv =====
module wma_datapath import wma_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [LEN_W-1:0]        i_cfg_data,
    input  logic signed [SMP_W-1:0] i_sample,
    input  logic [TS_W-1:0]         i_time_stamp,
    input  logic                    i_out_ready,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    output logic                    o_out_valid,
    output logic                    o_updated,
    output logic signed [SMP_W-1:0] o_average,
    output logic signed [SUM_W-1:0] o_running_sum,
    output logic [TS_W-1:0]         o_latched_stamp
);

    // ring memory, valid bits stand in for the zero reset
    logic [SMP_W-1:0]      r_ring [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_ring_vld, n_ring_vld;
    logic [SMP_W-1:0]      r_rd_data;
    logic                  r_rd_vld;

    logic [LEN_W-1:0]        r_len, n_len;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic                    r_filled, n_filled;
    logic signed [SMP_W-1:0] r_avg, n_avg;
    logic [TS_W-1:0]         r_stamp, n_stamp;
    logic                    r_upd, n_upd;

    logic signed [SMP_W-1:0] r_smp;
    logic [TS_W-1:0]         r_ts;

    // serial divider
    logic [SUM_W-1:0] r_quo;
    logic [LEN_W-1:0] r_rem;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;

    logic                    r_o_vld;
    logic signed [SUM_W-1:0] w_old;
    logic signed [SUM_W-1:0] w_smp_x;
    logic signed [SUM_W-1:0] w_new_sum;
    logic [SUM_W-1:0]        w_abs;
    logic [IDX_W-1:0]        w_idx_nx;
    logic                    w_wrap;
    logic                    w_ring_we;
    logic [LEN_W:0]          w_rem_sh;
    logic                    w_ge;
    logic [LEN_W:0]          w_rem_sub;
    logic [SMP_W-1:0]        w_q;

    assign w_smp_x   = {{(SUM_W-SMP_W){r_smp[SMP_W-1]}}, r_smp};
    assign w_old     = r_rd_vld ? {{(SUM_W-SMP_W){r_rd_data[SMP_W-1]}}, r_rd_data}
                                : '0;
    assign w_new_sum = r_sum - w_old + w_smp_x;
    assign w_abs     = w_new_sum[SUM_W-1] ? (~w_new_sum + 1'b1) : w_new_sum;
    assign w_idx_nx  = r_idx + 1'b1;
    assign w_wrap    = (r_len != '0) && ({{(LEN_W-IDX_W){1'b0}}, w_idx_nx} == r_len);
    assign w_ring_we = i_cmd.upd && (r_len != '0);

    assign w_rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign w_ge      = w_rem_sh >= {1'b0, r_len};
    assign w_rem_sub = w_ge ? (w_rem_sh - {1'b0, r_len}) : w_rem_sh;
    assign w_q       = r_quo[SMP_W-1:0];

    assign o_sts.wrap     = w_wrap;
    assign o_sts.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_sts.out_free = !r_o_vld || i_out_ready;
    assign o_out_valid    = r_o_vld;

    always_comb begin
        n_len      = r_len;
        n_sum      = r_sum;
        n_idx      = r_idx;
        n_filled   = r_filled;
        n_avg      = r_avg;
        n_stamp    = r_stamp;
        n_upd      = r_upd;
        n_ring_vld = r_ring_vld;
        if (i_cfg_we) begin
            n_len      = i_cfg_data;
            n_sum      = '0;
            n_idx      = '0;
            n_filled   = 1'b0;
            n_avg      = '0;
            n_stamp    = '0;
            n_ring_vld = '0;
        end else if (i_cmd.upd) begin
            if (r_len == '0) begin
                n_avg   = r_smp;
                n_sum   = w_smp_x;
                n_stamp = r_ts;
                n_upd   = 1'b1;
            end else begin
                n_sum             = w_new_sum;
                n_ring_vld[r_idx] = 1'b1;
                if (w_wrap) begin
                    n_idx    = '0;
                    n_stamp  = r_ts;
                    n_filled = 1'b1;
                    n_upd    = 1'b1;
                end else begin
                    n_idx = w_idx_nx;
                    n_upd = !r_filled;
                    if (!r_filled) begin
                        n_avg   = r_smp;
                        n_stamp = r_ts;
                    end
                end
            end
        end else if (i_cmd.div_fin) begin
            n_avg = r_neg ? (~w_q + 1'b1) : w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_sum      <= '0;
            r_idx      <= '0;
            r_filled   <= 1'b0;
            r_avg      <= '0;
            r_stamp    <= '0;
            r_upd      <= 1'b0;
            r_ring_vld <= '0;
            r_o_vld    <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_len      <= n_len;
            r_sum      <= n_sum;
            r_idx      <= n_idx;
            r_filled   <= n_filled;
            r_avg      <= n_avg;
            r_stamp    <= n_stamp;
            r_upd      <= n_upd;
            r_ring_vld <= n_ring_vld;
            if (i_cmd.rd) begin
                r_rd_vld <= r_ring_vld[r_idx];
            end
            if (i_cmd.out_load) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
            if (i_cmd.upd) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // ring memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_ring[r_idx];
        end
        if (w_ring_we) begin
            r_ring[r_idx] <= r_smp;
        end
    end

    // captured word and divider payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_smp <= i_sample;
            r_ts  <= i_time_stamp;
        end
        if (i_cmd.upd) begin
            r_quo <= w_abs;
            r_rem <= '0;
            r_neg <= w_new_sum[SUM_W-1];
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
            r_rem <= w_rem_sub[LEN_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_updated       <= r_upd;
            o_average       <= r_avg;
            o_running_sum   <= r_sum;
            o_latched_stamp <= r_stamp;
        end
    end

endmodule

// ===== rtl/windowed_moving_average_latch.sv =====
// flow: a taken sample passes ring read and sum update, on a window wrap the 30-step serial
// divider and sign fix, then waits for a free output register; one sample is in flight at a
// time; the next is taken once its result is loaded; the single-port ring read precedes the sum
// reset: synchronous active low; clears window length, sum, index, held values and ring valid
// bits at once, so no clearing pass follows reset or a window length write
module windowed_moving_average_latch import wma_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_data,
    wma_in_if.sink           i_smp,
    wma_out_if.source        o_res
);

    // command and status between the sequencer and the datapath
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer: idle -> ring read -> sum update -> (divide -> sign fix) -> output
    wma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (i_smp.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: 64-entry ring, running sum, held average and stamp,
    // one-bit-per-cycle restoring divider on the sum magnitude, output register
    wma_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_sample        (i_smp.sample),
        .i_time_stamp    (i_smp.time_stamp),
        .i_out_ready     (o_res.ready),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out_valid     (o_res.valid),
        .o_updated       (o_res.updated),
        .o_average       (o_res.average),
        .o_running_sum   (o_res.running_sum),
        .o_latched_stamp (o_res.latched_stamp)
    );

`ifndef SYNTH
    // one word in flight: no second word taken right after one is accepted
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> !i_smp.ready)
        else $error("input taken while a word is in flight");

    // a result only appears after the sequencer loads it
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(w_cmd.out_load))
        else $error("output valid without a load");

    // a wrapping word goes straight into the divider
    a_wrap_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.upd && w_sts.wrap) |=> w_cmd.div_step)
        else $error("window wrap did not start the divider");
`endif

endmodule
